/* rtl/matrix_factorization_sgd_step_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the matrix factorisation training block
// Concurrent checks are compiled for simulation only.
// ----------------------------------------------------------------------------
`ifndef MATRIX_FACTORIZATION_SGD_STEP_DEFINES_SVH
`define MATRIX_FACTORIZATION_SGD_STEP_DEFINES_SVH
`ifndef SYNTHESIS
`define MFSGD_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`define MFSGD_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define MFSGD_ASSERT_NEVER(label, cond, msg)
`define MFSGD_ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

/* rtl/mfsgd_pkg.sv */
// ----------------------------------------------------------------------------
// mfsgd_pkg
// Types, constants and arithmetic helpers of the matrix factorisation block.
// ----------------------------------------------------------------------------
package mfsgd_pkg;

	typedef enum logic [2:0] {
		OP_TRAIN       = 3'd0,
		OP_PREDICT     = 3'd1,
		OP_WR_UFACTOR  = 3'd2,
		OP_WR_IFACTOR  = 3'd3,
		OP_WR_UBIAS    = 3'd4,
		OP_WR_IBIAS    = 3'd5,
		OP_END_EPOCH   = 3'd6,
		OP_CLEAR_LOSS  = 3'd7
	} opcode_t;

	typedef enum logic [2:0] {
		CFG_GLOBAL_MEAN  = 3'd0,
		CFG_LEARN_RATE   = 3'd1,
		CFG_REGULARISE   = 3'd2,
		CFG_DECAY        = 3'd3,
		CFG_FACTOR_COUNT = 3'd4,
		CFG_USER_COUNT   = 3'd5,
		CFG_ITEM_COUNT   = 3'd6
	} cfg_index_t;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_EXEC = 7'b0000010,
		S_DOT  = 7'b0000100,
		S_DOTW = 7'b0001000,
		S_UPD  = 7'b0010000,
		S_UPW  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;

	localparam logic [47:0] EPS_LOSS      = 48'd168;
	localparam logic [15:0] RATE_RESET    = 16'd655;
	localparam logic [15:0] LAMBDA_RESET  = 16'd6554;
	localparam logic [6:0]  FACTORS_RESET = 7'd64;
	localparam logic [10:0] COUNT_RESET   = 11'd1024;

	function automatic logic signed [15:0] sat16(input logic signed [31:0] x);
		if (x > 32'sd32767)
			return 16'sh7fff;
		if (x < -32'sd32768)
			return 16'sh8000;
		return x[15:0];
	endfunction

	function automatic logic [47:0] loss_add(input logic [47:0] a, input logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? '1 : s[47:0];
	endfunction

endpackage

/* rtl/mfsgd_ram.sv */
// ----------------------------------------------------------------------------
// mfsgd_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mfsgd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

/* rtl/matrix_factorization_sgd_step.sv */
// ----------------------------------------------------------------------------
// matrix_factorization_sgd_step
// Biased matrix factorisation trained by stochastic gradient descent.
// ----------------------------------------------------------------------------
// Train runs a prediction pass and an update pass over the n active factors,
// predict only the prediction pass; one request is in work at a time.
// Each pass reads one factor per cycle through the factor memories' read port.
// Asynchronous reset clears control and loss and sets the configuration to its
// defaults; the factor and bias memories are not cleared and must be written before use.
`include "matrix_factorization_sgd_step_defines.svh"

module matrix_factorization_sgd_step #(
	parameter int MAX_USERS   = 1024,
	parameter int MAX_ITEMS   = 1024,
	parameter int MAX_FACTORS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// user_index[9:0], item_index[19:10], factor_index[25:20], value[41:26]
	input  logic [47:0] s_tdata,
	// opcode[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// prediction[15:0], loss_value[63:16], converged[64], index_error[65]
	output logic [71:0] m_tdata
);
	import mfsgd_pkg::*;

	localparam int UFD = MAX_USERS * MAX_FACTORS;
	localparam int IFD = MAX_ITEMS * MAX_FACTORS;
	localparam int UFA = UFD > 1 ? $clog2(UFD) : 1;
	localparam int IFA = IFD > 1 ? $clog2(IFD) : 1;
	localparam int UBA = MAX_USERS > 1 ? $clog2(MAX_USERS) : 1;
	localparam int IBA = MAX_ITEMS > 1 ? $clog2(MAX_ITEMS) : 1;
	localparam int SW  = $clog2(MAX_FACTORS + 1);
	localparam int FW  = MAX_FACTORS > 1 ? $clog2(MAX_FACTORS) : 1;
	localparam logic [16:0] MAXU = 17'(MAX_USERS);
	localparam logic [16:0] MAXI = 17'(MAX_ITEMS);
	localparam logic [10:0] MAXF = 11'(MAX_FACTORS);

	state_t state_q;

	logic signed [15:0] gm_q;
	logic [15:0] rate_q, lambda_q, decay_q;
	logic [6:0]  fcount_q;
	logic [10:0] ucount_q, icount_q;
	logic [47:0] loss_q, prev_q;

	opcode_t op_q;
	logic [9:0] u_q, i_q;
	logic [5:0] fi_q;
	logic signed [15:0] val_q;
	logic [SW-1:0] n_q, s_q;

	logic signed [31:0] acc_q;
	logic signed [15:0] pred_q;
	logic signed [16:0] e_q;

	logic signed [15:0] res_pred_q;
	logic res_conv_q, res_err_q;
	logic m_valid_q;
	logic signed [15:0] out_pred_q;
	logic [47:0] out_loss_q;
	logic out_conv_q, out_err_q;

	// Pipeline registers of the prediction and update passes; stages 3 and 4 serve only the update pass.
	logic v_s1, v_s2, v_s3, v_s4;
	logic bias_s1, bias_s2, bias_s3, bias_s4;
	logic [FW-1:0] f_s1, f_s2, f_s3, f_s4;
	logic signed [31:0] term_s2;
	logic signed [15:0] p_s2, q_s2, p_s3, q_s3, p_s4, q_s4;
	logic signed [20:0] eq_s2, ep_s2;
	logic signed [16:0] lp_s2, lq_s2;
	logic [31:0] pp_s2, qq_s2, lpp_s3, lqq_s3;
	logic signed [21:0] gu_s3, gi_s3;
	logic signed [22:0] du_s4, di_s4;
	logic [32:0] term_s4;

	// Memory ports.
	logic uf_we, if_we, ub_we, ib_we;
	logic [UFA-1:0] uf_waddr, uf_raddr;
	logic [IFA-1:0] if_waddr, if_raddr;
	logic [UBA-1:0] ub_addr;
	logic [IBA-1:0] ib_addr;
	logic [15:0] uf_wdata, if_wdata, ub_wdata, ib_wdata;
	logic [15:0] uf_rd, if_rd, ub_rd, ib_rd;

	// Combinational helpers.
	logic ubad, ibad, fi_ok, pass2, issue, drained1, drained2, out_load;
	logic [10:0] nsel;
	logic [SW-1:0] s_m1;
	logic [FW-1:0] f_rd;
	logic [31:0] ubase, ibase, u_ext, i_ext;
	logic [31:0] uf_ra_full, if_ra_full, uf_wa_full, if_wa_full;
	logic signed [15:0] p_b, q_b, pred_c, nu_e, ni_e;
	logic signed [16:0] bsum, lam_s, rate_s;
	logic signed [31:0] pq, ppf, qqf;
	logic signed [32:0] eqf, epf, lpf, lqf;
	logic [47:0] lppf, lqqf, half, rprod48;
	logic signed [38:0] duf, dif;
	logic signed [33:0] esq;
	logic conv_c;
	logic [31:0] rprod;

	assign u_ext = 32'(u_q);
	assign i_ext = 32'(i_q);
	assign ubase = u_ext * 32'(MAX_FACTORS);
	assign ibase = i_ext * 32'(MAX_FACTORS);
	assign ubad  = ({7'b0, u_q} >= {6'b0, ucount_q}) || ({7'b0, u_q} >= MAXU);
	assign ibad  = ({7'b0, i_q} >= {6'b0, icount_q}) || ({7'b0, i_q} >= MAXI);
	assign fi_ok = {5'b0, fi_q} < MAXF;
	assign nsel  = ({4'b0, fcount_q} > MAXF) ? MAXF : {4'b0, fcount_q};
	assign s_m1  = s_q - SW'(1);
	assign f_rd  = s_m1[FW-1:0];
	assign pass2 = (state_q == S_UPD) || (state_q == S_UPW);
	assign issue = (state_q == S_DOT) || (state_q == S_UPD);
	assign drained1 = !v_s1 && !v_s2;
	assign drained2 = drained1 && !v_s3 && !v_s4;
	assign out_load = (state_q == S_OUT) && (!m_valid_q || m_tready);

	assign uf_ra_full = ubase + 32'(f_rd);
	assign if_ra_full = ibase + 32'(f_rd);
	assign uf_raddr   = uf_ra_full[UFA-1:0];
	assign if_raddr   = if_ra_full[IFA-1:0];
	assign ub_addr    = u_ext[UBA-1:0];
	assign ib_addr    = i_ext[IBA-1:0];

	// Stage one: data from the memories.
	assign p_b   = bias_s1 ? signed'(ub_rd) : signed'(uf_rd);
	assign q_b   = bias_s1 ? signed'(ib_rd) : signed'(if_rd);
	assign bsum  = 17'(p_b) + 17'(q_b);
	assign pq    = p_b * q_b;
	assign lam_s = signed'({1'b0, lambda_q});
	assign eqf   = e_q * q_b;
	assign epf   = e_q * p_b;
	assign lpf   = lam_s * p_b;
	assign lqf   = lam_s * q_b;
	assign ppf   = p_b * p_b;
	assign qqf   = q_b * q_b;
	// Stage two to four.
	assign lppf  = 48'(lambda_q) * 48'(pp_s2);
	assign lqqf  = 48'(lambda_q) * 48'(qq_s2);
	assign rate_s = signed'({1'b0, rate_q});
	assign duf   = rate_s * gu_s3;
	assign dif   = rate_s * gi_s3;
	assign nu_e  = sat16(32'(p_s4) + 32'(du_s4));
	assign ni_e  = sat16(32'(q_s4) + 32'(di_s4));
	assign uf_wa_full = ubase + 32'(f_s4);
	assign if_wa_full = ibase + 32'(f_s4);

	assign pred_c = sat16(acc_q);
	assign esq    = e_q * e_q;
	assign half   = {1'b0, loss_q[47:1]};
	assign conv_c = (half < EPS_LOSS) || ((prev_q > half) && ((prev_q - half) < EPS_LOSS));
	assign rprod  = 32'(rate_q) * 32'(decay_q);
	assign rprod48 = 48'(rprod);

	always_comb begin
		uf_we = 1'b0;
		if_we = 1'b0;
		ub_we = 1'b0;
		ib_we = 1'b0;
		uf_waddr = uf_wa_full[UFA-1:0];
		if_waddr = if_wa_full[IFA-1:0];
		uf_wdata = nu_e;
		if_wdata = ni_e;
		ub_wdata = nu_e;
		ib_wdata = ni_e;
		if (state_q == S_EXEC) begin
			uf_wdata = val_q;
			if_wdata = val_q;
			ub_wdata = val_q;
			ib_wdata = val_q;
			uf_waddr = uf_ra_full[UFA-1:0];
			if_waddr = if_ra_full[IFA-1:0];
			case (op_q)
				OP_WR_UFACTOR: begin
					uf_we = !ubad && fi_ok;
					uf_waddr = UFA'(ubase + 32'(fi_q));
				end
				OP_WR_IFACTOR: begin
					if_we = !ibad && fi_ok;
					if_waddr = IFA'(ibase + 32'(fi_q));
				end
				OP_WR_UBIAS: ub_we = !ubad;
				OP_WR_IBIAS: ib_we = !ibad;
				default: ;
			endcase
		end else if (v_s4) begin
			uf_we = !bias_s4;
			if_we = !bias_s4;
			ub_we = bias_s4;
			ib_we = bias_s4;
		end
	end

	mfsgd_ram #(.WIDTH(16), .DEPTH(UFD)) u_uf_ram (
		.clk(clk), .we(uf_we), .waddr(uf_waddr), .wdata(uf_wdata),
		.raddr(uf_raddr), .rdata(uf_rd));
	mfsgd_ram #(.WIDTH(16), .DEPTH(IFD)) u_if_ram (
		.clk(clk), .we(if_we), .waddr(if_waddr), .wdata(if_wdata),
		.raddr(if_raddr), .rdata(if_rd));
	mfsgd_ram #(.WIDTH(16), .DEPTH(MAX_USERS)) u_ub_ram (
		.clk(clk), .we(ub_we), .waddr(ub_addr), .wdata(ub_wdata),
		.raddr(ub_addr), .rdata(ub_rd));
	mfsgd_ram #(.WIDTH(16), .DEPTH(MAX_ITEMS)) u_ib_ram (
		.clk(clk), .we(ib_we), .waddr(ib_addr), .wdata(ib_wdata),
		.raddr(ib_addr), .rdata(ib_rd));

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		bias_s1 <= (s_q == '0);
		f_s1    <= f_rd;
		bias_s2 <= bias_s1;
		f_s2    <= f_s1;
		p_s2    <= p_b;
		q_s2    <= q_b;
		term_s2 <= bias_s1 ? 32'(bsum) : (pq >>> 12);
		eq_s2   <= bias_s1 ? 21'(e_q) : 21'(eqf >>> 12);
		ep_s2   <= bias_s1 ? 21'(e_q) : 21'(epf >>> 12);
		lp_s2   <= 17'(lpf >>> 16);
		lq_s2   <= 17'(lqf >>> 16);
		pp_s2   <= ppf;
		qq_s2   <= qqf;
		bias_s3 <= bias_s2;
		f_s3    <= f_s2;
		p_s3    <= p_s2;
		q_s3    <= q_s2;
		gu_s3   <= 22'(eq_s2) - 22'(lp_s2);
		gi_s3   <= 22'(ep_s2) - 22'(lq_s2);
		lpp_s3  <= lppf[47:16];
		lqq_s3  <= lqqf[47:16];
		bias_s4 <= bias_s3;
		f_s4    <= f_s3;
		p_s4    <= p_s3;
		q_s4    <= q_s3;
		du_s4   <= 23'(duf >>> 16);
		di_s4   <= 23'(dif >>> 16);
		term_s4 <= 33'(lpp_s3) + 33'(lqq_s3);
		if (s_tvalid && s_tready) begin
			op_q  <= opcode_t'(s_tuser);
			u_q   <= s_tdata[9:0];
			i_q   <= s_tdata[19:10];
			fi_q  <= s_tdata[25:20];
			val_q <= signed'(s_tdata[41:26]);
		end
		if (out_load) begin
			out_pred_q <= res_pred_q;
			out_loss_q <= loss_q;
			out_conv_q <= res_conv_q;
			out_err_q  <= res_err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			gm_q       <= '0;
			rate_q     <= RATE_RESET;
			lambda_q   <= LAMBDA_RESET;
			decay_q    <= '0;
			fcount_q   <= FACTORS_RESET;
			ucount_q   <= COUNT_RESET;
			icount_q   <= COUNT_RESET;
			loss_q     <= '0;
			prev_q     <= '0;
			n_q        <= '0;
			s_q        <= '0;
			acc_q      <= '0;
			pred_q     <= '0;
			e_q        <= '0;
			res_pred_q <= '0;
			res_conv_q <= 1'b0;
			res_err_q  <= 1'b0;
			m_valid_q  <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && pass2;
			v_s4 <= v_s3;
			if (v_s2 && !pass2) begin
				acc_q <= acc_q + term_s2;
			end
			if (v_s4) begin
				loss_q <= loss_add(loss_q, 48'(term_s4));
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_pred_q <= '0;
					res_conv_q <= 1'b0;
					res_err_q  <= 1'b0;
					n_q        <= nsel[SW-1:0];
					s_q        <= '0;
					acc_q      <= 32'(gm_q);
					state_q    <= S_OUT;
					case (op_q)
						OP_TRAIN, OP_PREDICT: begin
							if (ubad || ibad) begin
								res_err_q  <= 1'b1;
								res_pred_q <= gm_q;
							end else begin
								state_q <= S_DOT;
							end
						end
						OP_WR_UFACTOR, OP_WR_UBIAS: res_err_q <= ubad;
						OP_WR_IFACTOR, OP_WR_IBIAS: res_err_q <= ibad;
						OP_END_EPOCH: begin
							loss_q     <= half;
							prev_q     <= half;
							res_conv_q <= conv_c;
							if (!conv_c && (rate_q != '0) && (decay_q != '0)) begin
								rate_q <= rprod48[31:16];
							end
						end
						default: loss_q <= '0;
					endcase
				end
				S_DOT, S_UPD: begin
					if (state_q == S_UPD && s_q == '0) begin
						loss_q <= loss_add(loss_q, 48'(esq));
					end
					if (s_q == n_q) begin
						state_q <= (state_q == S_DOT) ? S_DOTW : S_UPW;
					end else begin
						s_q <= s_q + SW'(1);
					end
				end
				S_DOTW: begin
					if (drained1) begin
						pred_q     <= pred_c;
						res_pred_q <= pred_c;
						e_q        <= 17'(val_q) - 17'(pred_c);
						s_q        <= '0;
						state_q    <= (op_q == OP_TRAIN) ? S_UPD : S_OUT;
					end
				end
				S_UPW: begin
					if (drained2) begin
						res_pred_q <= pred_q;
						state_q    <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (wr_en) begin
				case (wr_index)
					CFG_GLOBAL_MEAN:  gm_q <= signed'(wr_data);
					CFG_LEARN_RATE:   rate_q <= wr_data;
					CFG_REGULARISE:   lambda_q <= wr_data;
					CFG_DECAY:        decay_q <= wr_data;
					CFG_FACTOR_COUNT: fcount_q <= wr_data[6:0];
					CFG_USER_COUNT:   ucount_q <= wr_data[10:0];
					CFG_ITEM_COUNT:   icount_q <= wr_data[10:0];
					default: ;
				endcase
			end
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b0, out_err_q, out_conv_q, out_loss_q, out_pred_q};

	`MFSGD_ASSERT_IMPLY(a_idle_drained, s_tready, !(v_s1 || v_s2 || v_s3 || v_s4), "request taken while pipeline busy")
	`MFSGD_ASSERT_NEVER(a_write_clash, uf_we && ub_we, "factor and bias written together")
	`MFSGD_ASSERT_IMPLY(a_out_flags, m_valid_q, !(out_conv_q && out_err_q), "converged and index error both set")
endmodule
